FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the framer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define PCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcf assertion failed");

// Check cons in the cycle after ante
`define PCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcf assertion failed");

`endif

FILE: rtl/core/pcf_pkg.sv
// Types, constants and CRC byte fold for the PNG chunk framer
package pcf_pkg;

    localparam int unsigned FIELD_LEN_W = 31;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        CMD_BEGIN = 1'b0,
        CMD_DATA  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NO_CHUNK = 2'd1,
        ERR_ABANDON  = 2'd2
    } t_err;

    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] STEP_TYPE_LAST = 4'd7;
    localparam logic [3:0] STEP_CRC_FIRST = 4'd8;
    localparam logic [3:0] STEP_CRC_LAST  = 4'd11;

    localparam logic [1:0] GRP_LEN  = 2'd0;
    localparam logic [1:0] GRP_TYPE = 2'd1;
    localparam logic [1:0] GRP_CRC  = 2'd2;

    typedef struct packed {
        logic       init;
        logic       fold;
        logic [7:0] fold_byte;
    } t_crc_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       last;
        logic       done;
        t_err       err;
    } t_result;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/png_chunk_framer_crc32_top.sv
// An accepted item is held in the input register; each result is registered at the output.
// Throughput: one result per cycle unless i_ready stalls the output; a begin item issues
// its length and type bytes (and the CRC bytes for zero length), a data item its byte
// (and the CRC bytes when it closes the chunk). A new item is taken as the last byte issues.
// Reset: synchronous, active low; clears CRC to all ones and closes any chunk.
`include "assert_macros.svh"

module png_chunk_framer_crc32_top #(
    parameter int LENGTH_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [30:0] i_chunk_length,
    input  logic [31:0] i_chunk_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_chunk_done,
    output logic [1:0]  o_error_code
);

    pcf_pkg::t_crc_ctl crc_ctl;
    pcf_pkg::t_result  res;
    logic [31:0]       crc;
    logic              out_adv;

    logic              r_out_vld;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_done;
    pcf_pkg::t_err     r_out_err;

    assign out_adv = !r_out_vld || i_ready;

    pcf_seq #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_chunk_length (i_chunk_length),
        .i_chunk_type   (i_chunk_type),
        .i_data_byte    (i_data_byte),
        .i_adv          (out_adv),
        .i_crc          (crc),
        .o_crc_ctl      (crc_ctl),
        .o_res          (res)
    );

    pcf_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && res.valid) begin
            r_out_byte <= res.out_byte;
            r_out_last <= res.last;
            r_out_done <= res.done;
            r_out_err  <= res.err;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_chunk_done  = r_out_done;
    assign o_error_code  = r_out_err;

    `PCF_ASSERT_IMP(a_done_resets_crc, o_valid && o_chunk_done,
        crc == pcf_pkg::CRC_INIT)
    `PCF_ASSERT_IMP(a_no_chunk_single, o_valid && (o_error_code == pcf_pkg::ERR_NO_CHUNK),
        (o_out_byte == 8'd0) && o_last_of_run && !o_chunk_done)

endmodule

FILE: rtl/core/pcf_crc.sv
// CRC-32 register with init and byte fold
module pcf_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcf_pkg::t_crc_ctl i_ctl,
    output logic [31:0]       o_crc
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = pcf_pkg::CRC_INIT;
        end else if (i_ctl.fold) begin
            n_crc = pcf_pkg::crc_fold(r_crc, i_ctl.fold_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= pcf_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

FILE: rtl/core/pcf_seq.sv
// Input register, chunk state and per-byte result sequencer
`include "assert_macros.svh"

module pcf_seq #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [pcf_pkg::FIELD_LEN_W-1:0] i_chunk_length,
    input  logic [31:0]                   i_chunk_type,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_adv,
    input  logic [31:0]                   i_crc,
    output pcf_pkg::t_crc_ctl             o_crc_ctl,
    output pcf_pkg::t_result              o_res
);

    logic                   r_in_vld;
    pcf_pkg::t_cmd          r_cmd;
    logic [LENGTH_BITS-1:0] r_len;
    logic [31:0]            r_type;
    logic [7:0]             r_data;
    logic [3:0]             r_step;
    pcf_pkg::t_err          r_err;
    logic                   r_open;
    logic [LENGTH_BITS-1:0] r_remaining;

    logic                   adv;
    logic                   step_first;
    logic                   is_begin;
    logic                   data_closes;
    logic                   final_step;
    logic [LENGTH_BITS-1:0] rem_dec;
    pcf_pkg::t_err          err_now;
    logic [31:0]            len_word;
    logic [31:0]            word;
    logic [7:0]             word_byte;
    logic [7:0]             out_byte;
    logic [3:0]             n_step;

    assign adv        = r_in_vld && i_adv;
    assign step_first = (r_step == pcf_pkg::STEP_FIRST);
    assign is_begin   = (r_cmd == pcf_pkg::CMD_BEGIN);
    assign rem_dec    = r_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign data_closes = r_open && (rem_dec == '0);
    assign len_word   = {{(32-LENGTH_BITS){1'b0}}, r_len};

    always_comb begin
        if (!step_first) begin
            err_now = r_err;
        end else if (is_begin) begin
            err_now = r_open ? pcf_pkg::ERR_ABANDON : pcf_pkg::ERR_NONE;
        end else begin
            err_now = r_open ? pcf_pkg::ERR_NONE : pcf_pkg::ERR_NO_CHUNK;
        end
    end

    always_comb begin
        if (is_begin) begin
            final_step = ((r_step == pcf_pkg::STEP_TYPE_LAST) && (r_len != '0))
                      || (r_step == pcf_pkg::STEP_CRC_LAST);
        end else begin
            final_step = (step_first && !data_closes)
                      || (r_step == pcf_pkg::STEP_CRC_LAST);
        end
    end

    always_comb begin
        if (final_step) begin
            n_step = pcf_pkg::STEP_FIRST;
        end else if (!is_begin && step_first) begin
            n_step = pcf_pkg::STEP_CRC_FIRST;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_comb begin
        case (r_step[3:2])
            pcf_pkg::GRP_LEN:  word = len_word;
            pcf_pkg::GRP_TYPE: word = r_type;
            pcf_pkg::GRP_CRC:  word = ~i_crc;
            default:           word = '0;
        endcase
    end

    always_comb begin
        case (r_step[1:0])
            2'd0:    word_byte = word[31:24];
            2'd1:    word_byte = word[23:16];
            2'd2:    word_byte = word[15:8];
            default: word_byte = word[7:0];
        endcase
    end

    always_comb begin
        if (!is_begin && step_first) begin
            out_byte = r_open ? r_data : 8'd0;
        end else begin
            out_byte = word_byte;
        end
    end

    always_comb begin
        o_crc_ctl.init = adv && ((is_begin && step_first)
                      || (r_step == pcf_pkg::STEP_CRC_LAST));
        o_crc_ctl.fold = adv && ((is_begin && (r_step[3:2] == pcf_pkg::GRP_TYPE))
                      || (!is_begin && step_first && r_open));
        o_crc_ctl.fold_byte = is_begin ? word_byte : r_data;
    end

    always_comb begin
        o_res.valid    = adv;
        o_res.out_byte = out_byte;
        o_res.last     = final_step;
        o_res.done     = (r_step == pcf_pkg::STEP_CRC_LAST);
        o_res.err      = err_now;
    end

    assign o_ready = !r_in_vld || (adv && final_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_step      <= pcf_pkg::STEP_FIRST;
            r_open      <= 1'b0;
            r_remaining <= '0;
            r_err       <= pcf_pkg::ERR_NONE;
        end else begin
            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
            end else if (adv && final_step) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_step <= n_step;
                if (step_first) begin
                    r_err <= err_now;
                end
                if (r_step == pcf_pkg::STEP_CRC_LAST) begin
                    r_open      <= 1'b0;
                    r_remaining <= '0;
                end else if (step_first && is_begin) begin
                    r_open      <= 1'b1;
                    r_remaining <= r_len;
                end else if (step_first && r_open) begin
                    r_remaining <= rem_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd  <= pcf_pkg::t_cmd'(i_command);
            r_len  <= i_chunk_length[LENGTH_BITS-1:0];
            r_type <= i_chunk_type;
            r_data <= i_data_byte;
        end
    end

    `PCF_ASSERT_IMP(a_step_needs_item, r_step != pcf_pkg::STEP_FIRST, r_in_vld)
    `PCF_ASSERT_IMP(a_open_has_bytes, r_open && (r_remaining == '0),
        r_in_vld && (r_step != pcf_pkg::STEP_FIRST))
    `PCF_ASSERT_NXT(a_final_frees_input, adv && final_step && !i_valid, !r_in_vld)

endmodule
